[hdl/gbfo_pkg.sv]
// Shared types and constants for the greedy best-fit offset planner.
// No dependencies; compiled first.
`default_nettype none

package gbfo_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam int SIZE_W   = 32;
    localparam int OFFSET_W = 32;
    localparam int STEP_W   = 16;

    // One placed buffer as kept in the table memory.
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   size;
        logic [STEP_W-1:0]   first;
        logic [STEP_W-1:0]   last;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[hdl/gbfo_req_if.sv]
// Request channel: one buffer request word with valid/ready handshake.
// Depends on gbfo_pkg.
`default_nettype none

interface gbfo_req_if;
    logic                          valid;
    logic                          ready;
    logic                          start_plan;
    logic [gbfo_pkg::SIZE_W-1:0]   alloc_size;
    logic [gbfo_pkg::STEP_W-1:0]   first_step;
    logic [gbfo_pkg::STEP_W-1:0]   last_step;

    modport source (output valid, start_plan, alloc_size, first_step, last_step,
                    input ready);
    modport sink   (input valid, start_plan, alloc_size, first_step, last_step,
                    output ready);
endinterface

`default_nettype wire

[hdl/gbfo_rsp_if.sv]
// Result channel: assigned offset, running peak and full flag per word.
// Depends on gbfo_pkg.
`default_nettype none

interface gbfo_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [gbfo_pkg::OFFSET_W-1:0] offset;
    logic [gbfo_pkg::SIZE_W-1:0]   peak_size;
    logic                          table_full;

    modport source (output valid, offset, peak_size, table_full, input ready);
    modport sink   (input valid, offset, peak_size, table_full, output ready);
endinterface

`default_nettype wire

[hdl/gbfo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gbfo_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/greedy_best_fit_offset_planner_unit.sv]
// Greedy best-fit offset planner: top level with control and table memory.
// Depends on gbfo_pkg, gbfo_req_if, gbfo_rsp_if and gbfo_ram.
//
// Usage:
//   req (sink) takes one buffer request word: start_plan, alloc_size,
//   first_step, last_step. start_plan clears the table and the peak first.
//   rsp (source) returns one word per request: offset, peak_size, table_full.
//   The placed buffers live in one table RAM (one read, one write port),
//   kept sorted by offset. A request walks the n placed entries in offset
//   order, one RAM read per cycle, tracking the best fitting gap among
//   entries whose lifetimes overlap. Unless the table is full, the new
//   entry is then inserted by moving entries above it up one slot,
//   walking down from the top; a full table stores nothing and sets
//   table_full, and a zero-size request gets offset 0 and stores nothing.
//   The next request is taken in the cycle after the result is loaded,
//   not before: the block works one request at a time.
//   A finished result waits in the output register while the next request
//   is already being worked; only when a second result is ready and the
//   receiver still stalls does the block hold.
//   Reset empties the table (count zero) and clears the peak; RAM contents
//   are not cleared, entries past the count are never read.
`default_nettype none

module greedy_best_fit_offset_planner_unit #(
    parameter int MAX_ENTRIES = gbfo_pkg::MAX_ENTRIES_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    gbfo_req_if.sink   req,
    gbfo_rsp_if.source rsp
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        IDLE_S,
        SCAN_S,
        RESOLVE_S,
        PEAK_S,
        SHIFT_S,
        OUT_S
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [CW-1:0]               ptr_reg, ptr_next;
    logic                        pend_reg, pend_next;
    logic [IW-1:0]               tag_reg, tag_next;
    logic [gbfo_pkg::SIZE_W-1:0] peak_reg, peak_next;

    logic [gbfo_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [gbfo_pkg::STEP_W-1:0] first_reg, first_next;
    logic [gbfo_pkg::STEP_W-1:0] last_reg, last_next;

    // 33-bit running values: ends may pass 2^32 before saturation.
    logic [gbfo_pkg::OFFSET_W:0]   cur_reg, cur_next;
    logic [gbfo_pkg::OFFSET_W:0]   best_reg, best_next;
    logic [gbfo_pkg::OFFSET_W:0]   gap_reg, gap_next;
    logic                          have_reg, have_next;
    logic [gbfo_pkg::OFFSET_W-1:0] off_reg, off_next;
    logic                          full_reg, full_next;

    logic                          out_valid_reg, out_valid_next;
    logic [gbfo_pkg::OFFSET_W-1:0] out_off_reg, out_off_next;
    logic [gbfo_pkg::SIZE_W-1:0]   out_peak_reg, out_peak_next;
    logic                          out_full_reg, out_full_next;

    // table RAM
    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    gbfo_pkg::entry_t ram_wdata, ram_rdata;
    gbfo_pkg::entry_t new_entry;

    gbfo_ram #(
        .WIDTH (gbfo_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // per-entry scan terms
    logic                          overlap;
    logic [gbfo_pkg::OFFSET_W:0]   po;
    logic [gbfo_pkg::OFFSET_W+1:0] cur_plus;
    logic                          fits;
    logic [gbfo_pkg::OFFSET_W:0]   gap;
    logic [gbfo_pkg::OFFSET_W:0]   ent_end;
    logic [gbfo_pkg::OFFSET_W:0]   top_wide;
    logic [gbfo_pkg::SIZE_W-1:0]   top_sat;
    logic                          accept;
    logic [IW-1:0]                 tag_up;

    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == IDLE_S);

    assign po       = {1'b0, ram_rdata.offset};
    assign overlap  = !((ram_rdata.last < first_reg) || (ram_rdata.first > last_reg));
    assign cur_plus = {1'b0, cur_reg} + {2'b00, size_reg};
    assign fits     = (cur_plus <= {1'b0, po});
    assign gap      = po - cur_reg;
    assign ent_end  = po + {1'b0, ram_rdata.size};
    assign top_wide = {1'b0, off_reg} + {1'b0, size_reg};
    assign top_sat  = top_wide[gbfo_pkg::OFFSET_W] ? '1 : top_wide[gbfo_pkg::SIZE_W-1:0];
    assign tag_up   = IW'({1'b0, tag_reg} + 1'b1);

    assign new_entry.offset = off_reg;
    assign new_entry.size   = size_reg;
    assign new_entry.first  = first_reg;
    assign new_entry.last   = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        tag_next       = tag_reg;
        peak_next      = peak_reg;
        size_next      = size_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        gap_next       = gap_reg;
        have_next      = have_reg;
        off_next       = off_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        out_off_next   = out_off_reg;
        out_peak_next  = out_peak_reg;
        out_full_next  = out_full_reg;
        ram_we         = 1'b0;
        ram_waddr      = tag_up;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = ptr_reg[IW-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE_S:
            begin
                if (accept)
                begin
                    size_next  = req.alloc_size;
                    first_next = req.first_step;
                    last_next  = req.last_step;
                    cur_next   = '0;
                    have_next  = 1'b0;
                    ptr_next   = '0;
                    off_next   = '0;
                    full_next  = 1'b0;
                    if (req.start_plan)
                    begin
                        cnt_next  = '0;
                        peak_next = '0;
                    end
                    // zero size: offset 0, nothing stored
                    state_next = (req.alloc_size == '0) ? OUT_S : SCAN_S;
                end
            end

            SCAN_S:
            begin
                if (ptr_reg < cnt_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[IW-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg && overlap)
                begin
                    if (fits && (!have_reg || (gap < gap_reg)))
                    begin
                        have_next = 1'b1;
                        best_next = cur_reg;
                        gap_next  = gap;
                    end
                    if (ent_end > cur_reg)
                    begin
                        cur_next = ent_end;
                    end
                end
                if (!pend_reg && (ptr_reg == cnt_reg))
                begin
                    state_next = RESOLVE_S;
                end
            end

            RESOLVE_S:
            begin
                // best fitting gap if one was found, else past the highest overlapping end
                if (have_reg)
                begin
                    off_next = best_reg[gbfo_pkg::OFFSET_W] ? '1
                                                           : best_reg[gbfo_pkg::OFFSET_W-1:0];
                end
                else
                begin
                    off_next = cur_reg[gbfo_pkg::OFFSET_W] ? '1
                                                          : cur_reg[gbfo_pkg::OFFSET_W-1:0];
                end
                state_next = PEAK_S;
            end

            PEAK_S:
            begin
                if (top_sat > peak_reg)
                begin
                    peak_next = top_sat;
                end
                ptr_next = cnt_reg;
                if (cnt_reg >= MAX_CNT)
                begin
                    full_next  = 1'b1;
                    state_next = OUT_S;
                end
                else
                begin
                    state_next = SHIFT_S;
                end
            end

            SHIFT_S:
            begin
                // walk down from the top, moving larger offsets up one slot
                if (ptr_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = IW'(ptr_reg - 1'b1);
                    ptr_next  = ptr_reg - 1'b1;
                    tag_next  = IW'(ptr_reg - 1'b1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = tag_up;
                    if (ram_rdata.offset > off_reg)
                    begin
                        ram_wdata = ram_rdata;
                    end
                    else
                    begin
                        ram_wdata  = new_entry;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = OUT_S;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    // every placed entry lies above: new one goes first
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = new_entry;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = OUT_S;
                end
            end

            OUT_S:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = off_reg;
                    out_peak_next  = peak_reg;
                    out_full_next  = full_reg;
                    state_next     = IDLE_S;
                end
            end

            default:
            begin
                state_next = IDLE_S;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE_S;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            tag_reg       <= '0;
            peak_reg      <= '0;
            size_reg      <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            cur_reg       <= '0;
            best_reg      <= '0;
            gap_reg       <= '0;
            have_reg      <= 1'b0;
            off_reg       <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_off_reg   <= '0;
            out_peak_reg  <= '0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            tag_reg       <= tag_next;
            peak_reg      <= peak_next;
            size_reg      <= size_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            cur_reg       <= cur_next;
            best_reg      <= best_next;
            gap_reg       <= gap_next;
            have_reg      <= have_next;
            off_reg       <= off_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
            out_off_reg   <= out_off_next;
            out_peak_reg  <= out_peak_next;
            out_full_reg  <= out_full_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.offset     = out_off_reg;
    assign rsp.peak_size  = out_peak_reg;
    assign rsp.table_full = out_full_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("placed count exceeds table depth");

    a_write_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == SHIFT_S))
        else $error("table write outside insert walk");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != IDLE_S) |=> (cnt_reg == $past(cnt_reg))
                               || (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("placed count moved by more than one");

    a_full_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == OUT_S) && full_reg) |-> (cnt_reg == MAX_CNT))
        else $error("full flag with room in table");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != IDLE_S))
        else $error("accepted word not worked");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for greedy_best_fit_offset_planner_unit: directed and random
// buffer requests, with offsets and peaks checked against an in-bench planner.
// Depends on gbfo_pkg, gbfo_req_if, gbfo_rsp_if and the planner RTL.
`default_nettype none

module tb;

    localparam int DEPTH       = gbfo_pkg::MAX_ENTRIES_DEF;
    localparam int QUIET_LIMIT = 4000;       // cycles with no word moving on either side
    localparam int LONG_HOLD   = 500;        // receiver hold-off that backs the block up
    localparam int HOLD_AT     = 250;        // results seen before that hold-off starts
    localparam int CALM_LEFT   = 120;        // no idling once fewer requests remain queued
    localparam int DRAIN_WAIT  = 2 * DEPTH + 20;
    localparam int RANDOM_REQS = 1400;

    // One buffer request word as queued for the driver.
    typedef struct packed {
        logic                        start;
        logic [gbfo_pkg::SIZE_W-1:0] size;
        logic [gbfo_pkg::STEP_W-1:0] first;
        logic [gbfo_pkg::STEP_W-1:0] last;
    } request_t;

    // One expected result word.
    typedef struct packed {
        logic [gbfo_pkg::OFFSET_W-1:0] offset;
        logic [gbfo_pkg::SIZE_W-1:0]   peak;
        logic                          full;
    } placement_t;

    logic clk;
    logic rst_n;

    gbfo_req_if req_ch ();
    gbfo_rsp_if rsp_ch ();

    greedy_best_fit_offset_planner_unit #(
        .MAX_ENTRIES(DEPTH)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Bench-side copy of the planner state.
    gbfo_pkg::entry_t            arena_tab [DEPTH];
    int                          arena_cnt;
    logic [gbfo_pkg::SIZE_W-1:0] arena_peak;

    request_t            request_q [$];    // requests not yet offered
    placement_t          placement_q [$];  // results owed by the block, oldest first

    int                  errors;
    int                  results_seen;
    int                  quiet_cycles;

    // Driver / monitor housekeeping.
    request_t            nxt_req;
    placement_t          want;
    int                  send_idle;
    int                  send_pct;
    int                  send_cycle;
    int                  recv_idle;
    int                  recv_pct;
    int                  recv_cycle;
    int                  hold_left;
    bit                  hold_done;

    // Clock and the single reset pulse.
    initial
    begin
        rst_n = 1'b0;
        clk   = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Idle density for the next stretch: none, light or heavy.
    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    // Planner prediction: best-fit gap among overlapping live buffers,
    // else just past their highest end; then insert in offset order.
    function automatic placement_t plan_place(request_t r);
        placement_t                  res;
        logic [63:0]                 cur;
        logic [63:0]                 best;
        logic [63:0]                 best_gap;
        logic [63:0]                 gap;
        logic [63:0]                 end_pos;
        logic [63:0]                 top;
        logic [63:0]                 po;
        logic [gbfo_pkg::SIZE_W-1:0] off;
        bit                          have_best;
        int                          n;
        int                          pos;

        if (r.start)
        begin
            arena_cnt  = 0;
            arena_peak = '0;
        end
        n = (arena_cnt > DEPTH) ? DEPTH : arena_cnt;

        // zero size: nothing stored, peak untouched
        if (r.size == '0)
        begin
            res.offset = '0;
            res.peak   = arena_peak;
            res.full   = 1'b0;
            return res;
        end

        cur       = '0;
        best      = '0;
        best_gap  = '0;
        have_best = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            // lifetimes compared literally, inverted requests included
            if (arena_tab[i].last < r.first || arena_tab[i].first > r.last)
                continue;
            po = {32'd0, arena_tab[i].offset};
            if (cur + {32'd0, r.size} <= po)
            begin
                gap = po - cur;
                // strict compare: first of equal gaps wins
                if (!have_best || gap < best_gap)
                begin
                    have_best = 1'b1;
                    best      = cur;
                    best_gap  = gap;
                end
            end
            end_pos = po + {32'd0, arena_tab[i].size};
            if (end_pos > cur)
                cur = end_pos;
        end
        if (!have_best)
            best = cur;

        off = (best > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : best[31:0];
        top = {32'd0, off} + {32'd0, r.size};
        if (top > 64'hFFFF_FFFF)
            top = 64'hFFFF_FFFF;
        if (top[31:0] > arena_peak)
            arena_peak = top[31:0];

        res.offset = off;
        res.peak   = arena_peak;
        res.full   = 1'b0;
        if (n >= DEPTH)
        begin
            res.full = 1'b1;
        end
        else
        begin
            // after every entry with an equal offset
            pos = 0;
            while (pos < n && arena_tab[pos].offset <= off)
                pos++;
            for (int i = n; i > pos; i--)
                arena_tab[i] = arena_tab[i - 1];
            arena_tab[pos].offset = off;
            arena_tab[pos].size   = r.size;
            arena_tab[pos].first  = r.first;
            arena_tab[pos].last   = r.last;
            arena_cnt = n + 1;
        end
        return res;
    endfunction

    task automatic add_req(input logic st, input logic [gbfo_pkg::SIZE_W-1:0] sz,
                           input logic [gbfo_pkg::STEP_W-1:0] f,
                           input logic [gbfo_pkg::STEP_W-1:0] l);
        request_t r;
        r.start = st;
        r.size  = sz;
        r.first = f;
        r.last  = l;
        request_q = {request_q, r};
    endtask

    // One plan: len random requests; the first, and rarely a later one, starts a plan.
    // Mostly small sizes and short overlapping lifetimes so gaps form;
    // a sprinkle of zero, huge and fully random words.
    task automatic add_plan(input int len);
        logic [gbfo_pkg::SIZE_W-1:0] sz;
        logic [gbfo_pkg::STEP_W-1:0] f;
        logic [gbfo_pkg::STEP_W-1:0] l;
        int                          pick;
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                sz = '0;
            else if (pick < 8)
                sz = $urandom;
            else if (pick < 11)
                sz = 32'hFFFF_FFFF - $urandom_range(0, 255);
            else if (pick < 50)
                sz = $urandom_range(1, 48) * 16;
            else
                sz = $urandom_range(1, 300);

            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                f = 16'($urandom);
                l = 16'($urandom);
            end
            else
            begin
                f = 16'($urandom_range(0, 40));
                l = 16'(f + $urandom_range(0, 23));
                if (pick < 10)
                    l = 16'hFFFF;
            end
            add_req(k == 0 || $urandom_range(0, 199) == 0, sz, f, l);
        end
    endtask

    // Stimulus: directed words, then random plans.
    initial
    begin
        int queued;
        int len;
        int plan_no;

        // zero size on a fresh plan
        add_req(1'b1, 32'd0, 16'd0, 16'd0);
        // basic placement: stacked, then a gap below a later buffer
        add_req(1'b1, 32'd100, 16'd0, 16'd10);
        add_req(1'b0, 32'd50, 16'd5, 16'd20);
        add_req(1'b0, 32'd30, 16'd11, 16'd15);   // fits below, lands on offset 0 twice
        add_req(1'b0, 32'd20, 16'd0, 16'hFFFF);  // never freed, overlaps all
        add_req(1'b0, 32'd7, 16'd20, 16'd3);     // inverted lifetime
        add_req(1'b0, 32'd0, 16'd2, 16'd9);      // zero size keeps the peak
        // two equal gaps: the lower one wins, new entry after equal offset
        add_req(1'b1, 32'd8, 16'd0, 16'd9);
        add_req(1'b0, 32'd8, 16'd0, 16'd0);
        add_req(1'b0, 32'd8, 16'd0, 16'd9);
        add_req(1'b0, 32'd8, 16'd0, 16'd0);
        add_req(1'b0, 32'd8, 16'd0, 16'd9);
        add_req(1'b0, 32'd4, 16'd5, 16'd9);
        // arena overflow: offset and peak saturate
        add_req(1'b1, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
        add_req(1'b0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
        add_req(1'b0, 32'd1, 16'd0, 16'hFFFF);
        add_req(1'b0, 32'd0, 16'hFFFF, 16'hFFFF);
        // extremes of the step fields
        add_req(1'b1, 32'h8000_0001, 16'hFFFF, 16'hFFFF);
        add_req(1'b0, 32'h7FFF_FFFF, 16'h0000, 16'h0000);
        add_req(1'b0, 32'd1, 16'hFFFF, 16'h0000);

        queued  = 0;
        plan_no = 0;
        while (queued < RANDOM_REQS)
        begin
            // a few long plans can run the table past full
            if (plan_no == 1 || $urandom_range(0, 9) == 0)
                len = $urandom_range(DEPTH - 4, DEPTH + 16);
            else
                len = $urandom_range(1, 24);
            add_plan(len);
            queued += len;
            plan_no++;
        end

        @(posedge rst_n);
        while (request_q.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (placement_q.size() != 0)
            @(posedge clk);
        // catch any stray word after the last expected one
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Driver: holds a word until taken; idles in random bursts
    // except near the end of the run.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.start_plan <= 1'b0;
            req_ch.alloc_size <= '0;
            req_ch.first_step <= '0;
            req_ch.last_step  <= '0;
            send_idle         = 0;
            send_pct          = 0;
            send_cycle        = 0;
            arena_cnt         = 0;
            arena_peak        = '0;
        end
        else
        begin
            send_cycle++;
            if (send_cycle % 250 == 0)
                send_pct = pick_pct();

            if (req_ch.valid && req_ch.ready)
            begin
                nxt_req.start = req_ch.start_plan;
                nxt_req.size  = req_ch.alloc_size;
                nxt_req.first = req_ch.first_step;
                nxt_req.last  = req_ch.last_step;
                placement_q = {placement_q, plan_place(nxt_req)};
            end

            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_idle > 0)
                begin
                    send_idle--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_q.size() > CALM_LEFT && $urandom_range(0, 99) < send_pct)
                begin
                    // idle burst, this one included
                    send_idle = $urandom_range(0, 7);
                    req_ch.valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    nxt_req = request_q.pop_front();
                    req_ch.start_plan <= nxt_req.start;
                    req_ch.alloc_size <= nxt_req.size;
                    req_ch.first_step <= nxt_req.first;
                    req_ch.last_step  <= nxt_req.last;
                    req_ch.valid      <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest expectation
    // and drives ready, including one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_idle    = 0;
            recv_pct     = 0;
            recv_cycle   = 0;
            hold_left    = 0;
            hold_done    = 1'b0;
            results_seen = 0;
            errors       = 0;
        end
        else
        begin
            recv_cycle++;
            if (recv_cycle % 330 == 0)
                recv_pct = pick_pct();

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (placement_q.size() == 0)
                begin
                    $error("unexpected result word: offset %0h peak_size %0h table_full %0b",
                           rsp_ch.offset, rsp_ch.peak_size, rsp_ch.table_full);
                    errors++;
                end
                else
                begin
                    want = placement_q.pop_front();
                    if (rsp_ch.offset !== want.offset)
                    begin
                        $error("offset: expected %0h, actual %0h", want.offset, rsp_ch.offset);
                        errors++;
                    end
                    if (rsp_ch.peak_size !== want.peak)
                    begin
                        $error("peak_size: expected %0h, actual %0h",
                               want.peak, rsp_ch.peak_size);
                        errors++;
                    end
                    if (rsp_ch.table_full !== want.full)
                    begin
                        $error("table_full: expected %0b, actual %0b",
                               want.full, rsp_ch.table_full);
                        errors++;
                    end
                end
            end

            // long hold-off while the sender keeps offering
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (recv_idle > 0)
            begin
                recv_idle--;
                rsp_ch.ready <= 1'b0;
            end
            else if (request_q.size() > CALM_LEFT && $urandom_range(0, 99) < recv_pct)
            begin
                recv_idle = $urandom_range(0, 7);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long with no word moving on either side.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

`default_nettype wire
